/* design/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types, constants and control store of the line follower
// Widths of the payload and the loop state, the register map, the control
// word that drives the datapath and the microprogram that sequences it.
// ----------------------------------------------------------------------------
package lfpd_pkg;

   // Motor saturation bound, never beyond the reach of a 10-bit result
   localparam int MOTOR_LIMIT = 400;
   localparam int SAT_LIMIT   = (MOTOR_LIMIT > 511) ? 511 : MOTOR_LIMIT;

   // Field and state widths
   localparam int POS_W      = 12;
   localparam int ERR_W      = 12;
   localparam int MAG_W      = 11;
   localparam int SLOPE_W    = 13;
   localparam int SUM_W      = 18;
   localparam int BASE_W     = 10;
   localparam int SPEED_W    = 10;
   localparam int CORR_W     = 12;
   localparam int WHEEL_W    = 13;
   localparam int QUO_W      = 11;
   localparam int GAIN_W     = 8;
   localparam int LIMIT_W    = 16;
   localparam int SPD_W      = 9;
   localparam int PTL_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 4;

   // Shared multiplier and accumulator
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 23;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 43;
   localparam int QUO_IN_W = 20;

   // Arithmetic constants
   localparam logic [POS_W-1:0]          POS_MAX     = 12'd4000;
   localparam logic [POS_W-1:0]          POS_CENTRE  = 12'd2000;
   localparam logic [CORR_W-1:0]         SCALE_BASE  = 12'd1500;
   localparam int                        RECIP_SHIFT = 28;
   // ceil(2^28 / 375): quotient by 1500 after dropping two bits
   localparam logic [MUL_B_W-1:0]        RECIP_1500  = 23'd715828;
   // ceil(2^28 / 125): quotient by 2000 after dropping four bits
   localparam logic [MUL_B_W-1:0]        RECIP_2000  = 23'd2147484;
   // smallest magnitude whose scaled quotient no longer fits in 11 bits
   localparam logic signed [ACC_W-1:0]   CORR_BIG    = 43'sd3072000;
   localparam logic signed [SUM_W-1:0]   LEAK_BIAS   = 18'sd31;
   localparam int                        LEAK_SHIFT  = 5;
   localparam logic signed [CORR_W-1:0]  SLEW_UP     = 12'sd4;
   localparam logic signed [CORR_W-1:0]  SLEW_DOWN   = 12'sd12;
   localparam logic signed [WHEEL_W-1:0] WHEEL_MAX   = WHEEL_W'(SAT_LIMIT);
   localparam logic signed [WHEEL_W-1:0] WHEEL_MIN   = -WHEEL_W'(SAT_LIMIT);

   // Register reset values
   localparam logic [GAIN_W-1:0]  GAIN_P_RST   = 8'd1;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST   = 8'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST   = 8'd4;
   localparam logic [LIMIT_W-1:0] SUM_LIM_RST  = 16'd4000;
   localparam logic [SPD_W-1:0]   STRAIGHT_RST = 9'd300;
   localparam logic [SPD_W-1:0]   LOW_RST      = 9'd150;
   localparam logic [PTL_W-1:0]   PTL_RST      = 10'd200;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P          = 3'd0,
      CSR_GAIN_I          = 3'd1,
      CSR_GAIN_D          = 3'd2,
      CSR_SUM_LIMIT       = 3'd3,
      CSR_SPEED_STRAIGHT  = 3'd4,
      CSR_SPEED_LOW       = 3'd5,
      CSR_POST_TURN_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [LIMIT_W-1:0] sum_limit;
      logic [SPD_W-1:0]   speed_straight;
      logic [SPD_W-1:0]   speed_low;
      logic [PTL_W-1:0]   post_turn_limit;
   } csr_regs_type;

   // Control word fields
   typedef enum logic [2:0] {
      A_ERR   = 3'd0,
      A_SUM   = 3'd1,
      A_SLOPE = 3'd2,
      A_ACC   = 3'd3,
      A_MAG   = 3'd4,
      A_QUO   = 3'd5
   } a_sel_type;

   typedef enum logic [2:0] {
      B_GP      = 3'd0,
      B_GI      = 3'd1,
      B_GD      = 3'd2,
      B_SCALE   = 3'd3,
      B_SPAN    = 3'd4,
      B_RECIP_C = 3'd5,
      B_RECIP_T = 3'd6
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD = 3'd0,
      ACC_LOAD = 3'd1,
      ACC_ADD  = 3'd2,
      ACC_ABS2 = 3'd3,
      ACC_ABS4 = 3'd4
   } acc_op_type;

   typedef enum logic [3:0] {
      ST_NONE   = 4'd0,
      ST_ERROR  = 4'd1,
      ST_RELOAD = 4'd2,
      ST_SLOPE  = 4'd3,
      ST_LEAK   = 4'd4,
      ST_CORR   = 4'd5,
      ST_TARGET = 4'd6,
      ST_SLEW   = 4'd7,
      ST_EMIT   = 4'd8
   } st_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT = 2'd0,
      JMP_SKIP = 2'd1,
      JMP_DONE = 2'd2
   } jump_type;

   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      acc_op_type        acc_op;
      st_op_type         st_op;
      jump_type          jump;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_IDLE = '{
      a_sel:  A_ERR,
      b_sel:  B_GP,
      acc_op: ACC_HOLD,
      st_op:  ST_NONE,
      jump:   JMP_NEXT,
      target: '0
   };

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_ERROR   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_RELOAD  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_SLOPE   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_LEAK    = 4'd3;
   localparam logic [STEP_W-1:0] STEP_MAC_I   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_MAC_D   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_SCALE   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_ABS_C   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_DIV_C   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_CORR    = 4'd9;
   localparam logic [STEP_W-1:0] STEP_ABS_T   = 4'd10;
   localparam logic [STEP_W-1:0] STEP_DIV_T   = 4'd11;
   localparam logic [STEP_W-1:0] STEP_TARGET  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_SLEW    = 4'd13;
   localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd14;

   // Control store: one word per step
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      w = CTRL_IDLE;
      case (step)
         STEP_ERROR: begin
            w.st_op  = ST_ERROR;
            w.jump   = JMP_SKIP;
            w.target = STEP_SLOPE;
         end
         STEP_RELOAD: begin
            w.st_op = ST_RELOAD;
         end
         STEP_SLOPE: begin
            w.st_op = ST_SLOPE;
         end
         STEP_LEAK: begin
            w.st_op  = ST_LEAK;
            w.a_sel  = A_ERR;
            w.b_sel  = B_GP;
            w.acc_op = ACC_LOAD;
         end
         STEP_MAC_I: begin
            w.a_sel  = A_SUM;
            w.b_sel  = B_GI;
            w.acc_op = ACC_ADD;
         end
         STEP_MAC_D: begin
            w.a_sel  = A_SLOPE;
            w.b_sel  = B_GD;
            w.acc_op = ACC_ADD;
         end
         STEP_SCALE: begin
            w.a_sel  = A_ACC;
            w.b_sel  = B_SCALE;
            w.acc_op = ACC_LOAD;
         end
         STEP_ABS_C: begin
            w.acc_op = ACC_ABS2;
         end
         STEP_DIV_C: begin
            w.a_sel  = A_QUO;
            w.b_sel  = B_RECIP_C;
            w.acc_op = ACC_LOAD;
         end
         STEP_CORR: begin
            w.st_op  = ST_CORR;
            w.a_sel  = A_MAG;
            w.b_sel  = B_SPAN;
            w.acc_op = ACC_LOAD;
         end
         STEP_ABS_T: begin
            w.acc_op = ACC_ABS4;
         end
         STEP_DIV_T: begin
            w.a_sel  = A_QUO;
            w.b_sel  = B_RECIP_T;
            w.acc_op = ACC_LOAD;
         end
         STEP_TARGET: begin
            w.st_op = ST_TARGET;
         end
         STEP_SLEW: begin
            w.st_op = ST_SLEW;
         end
         STEP_EMIT: begin
            w.st_op = ST_EMIT;
            w.jump  = JMP_DONE;
         end
         default: begin
            w.jump = JMP_DONE;
         end
      endcase
      return w;
   endfunction

endpackage

/* design/lfpd_req_if.sv */
// ----------------------------------------------------------------------------
// lfpd_req_if: line position channel
// Valid/ready channel carrying one sensor sample and its turn flags.
// ----------------------------------------------------------------------------
interface lfpd_req_if import lfpd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic             turn_ahead;
   logic             after_turn;
   logic             restart;

   modport source (
      output valid, position, turn_ahead, after_turn, restart,
      input  ready
   );

   modport sink (
      input  valid, position, turn_ahead, after_turn, restart,
      output ready
   );
endinterface

/* design/lfpd_rsp_if.sv */
// ----------------------------------------------------------------------------
// lfpd_rsp_if: wheel drive channel
// Valid/ready channel carrying one pair of saturated motor drive values.
// ----------------------------------------------------------------------------
interface lfpd_rsp_if import lfpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] left_speed;
   logic signed [SPEED_W-1:0] right_speed;

   modport source (
      output valid, left_speed, right_speed,
      input  ready
   );

   modport sink (
      input  valid, left_speed, right_speed,
      output ready
   );
endinterface

/* design/lfpd_seq.sv */
// ----------------------------------------------------------------------------
// lfpd_seq: microprogram sequencer
// Step counter over the control store, with a skip on the restart flag and a
// hold on the final step while the result register is still occupied.
// ----------------------------------------------------------------------------
module lfpd_seq import lfpd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          restart_flag,
   input  logic          emit_wait,
   output ctrl_word_type ctrl,
   output logic          busy
);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_word_type     word;

   // Fetch the current control word; issue no-ops while idle
   assign word = ucode(step_ff);
   assign ctrl = busy_ff ? word : CTRL_IDLE;
   assign busy = busy_ff;

   // Advance, skip or finish
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = STEP_ERROR;
         end
      end else begin
         case (word.jump)
            JMP_DONE: begin
               if (!emit_wait) begin
                  busy_in = 1'b0;
               end
            end
            JMP_SKIP: begin
               step_in = restart_flag ? step_ff + 1'b1 : word.target;
            end
            default: begin
               step_in = step_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_ERROR;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

/* design/lfpd_dp.sv */
// ----------------------------------------------------------------------------
// lfpd_dp: PID datapath
// Loop state, one shared multiply-accumulate unit and the step operations
// selected by the control word; wheel speeds are formed from the result.
// ----------------------------------------------------------------------------
module lfpd_dp import lfpd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [POS_W-1:0]          position,
   input  logic                      turn_ahead,
   input  logic                      after_turn,
   input  logic                      restart,
   input  ctrl_word_type             ctrl,
   input  csr_regs_type              csr,
   output logic                      restart_flag,
   output logic signed [SPEED_W-1:0] left_speed,
   output logic signed [SPEED_W-1:0] right_speed
);

   // Sample registers
   logic [POS_W-1:0] pos_ff;
   logic             turn_ff, after_ff, restart_ff;

   // Loop state
   logic signed [ERR_W-1:0]   last_ff, last_in;
   logic signed [SLOPE_W-1:0] slope_ff, slope_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [BASE_W-1:0]  base_ff, base_in;

   // Working registers
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     sign_ff, sign_in;
   logic                     big_ff, big_in;
   logic signed [CORR_W-1:0] corr_ff, corr_in;
   logic signed [BASE_W-1:0] target_ff, target_in;

   // Combinational terms
   logic [POS_W-1:0]           pos_sat;
   logic signed [ERR_W-1:0]    err_calc;
   logic signed [SLOPE_W:0]    slope_raw, slope_adj, slope_half;
   logic signed [SUM_W-1:0]    sum_bias, sum_leak, sum_lim, sum_next;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_prod;
   logic signed [ACC_W-1:0]    prod_t, acc_abs;
   logic [CORR_W-1:0]          scale;
   logic signed [BASE_W-1:0]   span;
   logic [QUO_W-1:0]           q_raw, q_use;
   logic signed [CORR_W-1:0]   q_mag, q_signed, ptl, straight_ext, low_ext, tgt_calc;
   logic signed [CORR_W-1:0]   base_ext, target_ext, slew_up, slew_dn;
   logic signed [WHEEL_W-1:0]  wheel_l, wheel_r;

   assign restart_flag = restart_ff;

   // Saturate position and centre it
   assign pos_sat  = (pos_ff > POS_MAX) ? POS_MAX : pos_ff;
   assign err_calc = pos_sat - POS_CENTRE;

   // Halving average of the slope, truncated toward zero
   assign slope_raw  = (SLOPE_W+1)'(slope_ff) + (SLOPE_W+1)'(err_ff)
                     - (SLOPE_W+1)'(last_ff);
   assign slope_adj  = slope_raw + (slope_raw[SLOPE_W] ? 14'sd1 : 14'sd0);
   assign slope_half = slope_adj >>> 1;

   // Leak one thirty-second toward zero, then clamp
   assign sum_bias = sum_ff + (sum_ff[SUM_W-1] ? LEAK_BIAS : 18'sd0);
   assign sum_leak = sum_ff - (sum_bias >>> LEAK_SHIFT);
   assign sum_lim  = {2'b00, csr.sum_limit};
   always_comb begin
      if (sum_leak > sum_lim) begin
         sum_next = sum_lim;
      end else if (sum_leak < -sum_lim) begin
         sum_next = -sum_lim;
      end else begin
         sum_next = sum_leak;
      end
   end

   // Shared multiplier operands
   assign scale = SCALE_BASE + CORR_W'(mag_ff);
   assign span  = {1'b0, csr.speed_low} - {1'b0, csr.speed_straight};

   always_comb begin
      case (ctrl.a_sel)
         A_ERR:   mul_a = MUL_A_W'(err_ff);
         A_SUM:   mul_a = MUL_A_W'(sum_ff);
         A_SLOPE: mul_a = MUL_A_W'(slope_ff);
         A_ACC:   mul_a = acc_ff[MUL_A_W-1:0];
         A_MAG:   mul_a = MUL_A_W'(mag_ff);
         A_QUO:   mul_a = MUL_A_W'(acc_ff[QUO_IN_W-1:0]);
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      case (ctrl.b_sel)
         B_GP:      mul_b = MUL_B_W'(csr.gain_p);
         B_GI:      mul_b = MUL_B_W'(csr.gain_i);
         B_GD:      mul_b = MUL_B_W'(csr.gain_d);
         B_SCALE:   mul_b = MUL_B_W'(scale);
         B_SPAN:    mul_b = MUL_B_W'(span);
         B_RECIP_C: mul_b = RECIP_1500;
         B_RECIP_T: mul_b = RECIP_2000;
         default:   mul_b = '0;
      endcase
   end

   assign mul_prod = mul_a * mul_b;
   assign prod_t   = ACC_W'(mul_prod);
   assign acc_abs  = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;

   // Accumulator: load, accumulate, or fold to magnitude ahead of a quotient
   always_comb begin
      acc_in  = acc_ff;
      sign_in = sign_ff;
      big_in  = big_ff;
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = prod_t;
         ACC_ADD:  acc_in = acc_ff + prod_t;
         ACC_ABS2: begin
            acc_in  = acc_abs >>> 2;
            sign_in = acc_ff[ACC_W-1];
            big_in  = acc_abs >= CORR_BIG;
         end
         ACC_ABS4: begin
            acc_in  = acc_abs >>> 4;
            sign_in = acc_ff[ACC_W-1];
            big_in  = acc_abs >= CORR_BIG;
         end
         default: acc_in = acc_ff;
      endcase
   end

   // Signed quotient from the reciprocal product
   assign q_raw    = acc_ff[RECIP_SHIFT +: QUO_W];
   assign q_use    = big_ff ? '1 : q_raw;
   assign q_mag    = {1'b0, q_use};
   assign q_signed = sign_ff ? -q_mag : q_mag;

   assign ptl          = {2'b00, csr.post_turn_limit};
   assign straight_ext = {3'b000, csr.speed_straight};
   assign low_ext      = {3'b000, csr.speed_low};
   assign tgt_calc     = (turn_ff || after_ff) ? low_ext : straight_ext + q_signed;

   assign base_ext   = CORR_W'(base_ff);
   assign target_ext = CORR_W'(target_ff);
   assign slew_up    = base_ext + SLEW_UP;
   assign slew_dn    = base_ext - SLEW_DOWN;

   // Step operations on the loop state
   always_comb begin
      err_in    = err_ff;
      mag_in    = mag_ff;
      last_in   = last_ff;
      slope_in  = slope_ff;
      sum_in    = sum_ff;
      base_in   = base_ff;
      corr_in   = corr_ff;
      target_in = target_ff;
      case (ctrl.st_op)
         ST_ERROR: begin
            err_in = err_calc;
            mag_in = err_calc[ERR_W-1] ? MAG_W'(-err_calc) : MAG_W'(err_calc);
         end
         ST_RELOAD: begin
            last_in  = err_ff;
            slope_in = '0;
            sum_in   = '0;
            base_in  = {1'b0, csr.speed_low};
         end
         ST_SLOPE: begin
            slope_in = SLOPE_W'(slope_half);
            sum_in   = sum_ff + SUM_W'(err_ff);
            last_in  = err_ff;
         end
         ST_LEAK: begin
            sum_in = sum_next;
         end
         ST_CORR: begin
            if (after_ff && (q_signed > ptl)) begin
               corr_in = ptl;
            end else if (after_ff && (q_signed < -ptl)) begin
               corr_in = -ptl;
            end else begin
               corr_in = q_signed;
            end
         end
         ST_TARGET: begin
            target_in = tgt_calc[BASE_W-1:0];
         end
         ST_SLEW: begin
            if (target_ext > base_ext) begin
               base_in = (target_ext < slew_up) ? target_ff : slew_up[BASE_W-1:0];
            end else begin
               base_in = (target_ext > slew_dn) ? target_ff : slew_dn[BASE_W-1:0];
            end
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   // Wheel speeds: base plus and minus correction, saturated
   assign wheel_l = WHEEL_W'(base_ff) + WHEEL_W'(corr_ff);
   assign wheel_r = WHEEL_W'(base_ff) - WHEEL_W'(corr_ff);

   always_comb begin
      if (wheel_l > WHEEL_MAX) begin
         left_speed = WHEEL_MAX[SPEED_W-1:0];
      end else if (wheel_l < WHEEL_MIN) begin
         left_speed = WHEEL_MIN[SPEED_W-1:0];
      end else begin
         left_speed = wheel_l[SPEED_W-1:0];
      end
      if (wheel_r > WHEEL_MAX) begin
         right_speed = WHEEL_MAX[SPEED_W-1:0];
      end else if (wheel_r < WHEEL_MIN) begin
         right_speed = WHEEL_MIN[SPEED_W-1:0];
      end else begin
         right_speed = wheel_r[SPEED_W-1:0];
      end
   end

   // Loop state: reset clears it and loads the base speed with the default low speed
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         slope_ff <= '0;
         sum_ff   <= '0;
         base_ff  <= {1'b0, LOW_RST};
      end else begin
         last_ff  <= last_in;
         slope_ff <= slope_in;
         sum_ff   <= sum_in;
         base_ff  <= base_in;
      end
   end

   // Capture the sample on transfer; hold working values otherwise
   always_ff @(posedge clock) begin
      if (start) begin
         pos_ff     <= position;
         turn_ff    <= turn_ahead;
         after_ff   <= after_turn;
         restart_ff <= restart;
      end
      err_ff    <= err_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      sign_ff   <= sign_in;
      big_ff    <= big_in;
      corr_ff   <= corr_in;
      target_ff <= target_in;
   end

endmodule

/* design/line_follow_pid_drive.sv */
// ----------------------------------------------------------------------------
// line_follow_pid_drive: PID line follower for a differential drive
// Turns one line position sample into a saturated pair of wheel speeds.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries a position (2000 is centred) with turn_ahead, after_turn
//   and restart flags; rsp_chan returns left_speed and right_speed, each
//   clamped to the motor limit. Gains, limits and speeds are written through
//   csr_wr_en / csr_index / csr_wr_data while no sample is in flight.
//   Each sample runs a 14-step microprogram (15 steps when restart reloads
//   the loop state) over one shared multiply-accumulate unit (three gain
//   products, the speed scaling, two reciprocal quotients and the target map).
//   A new sample is taken only after the previous one has left its final
//   step, as req_chan.ready stays low while the sequencer is busy, so the
//   throughput is set by the single shared multiplier.
//   The result sits in an output register: if rsp_chan stalls, the next
//   sample is still taken and runs to its final step, where it holds until
//   the register is free; req_chan.ready stays low meanwhile.
//   Reset loads the register defaults, clears the loop state and sets the
//   base speed to the default low speed; it is synchronous to the clock.
// ----------------------------------------------------------------------------
module line_follow_pid_drive import lfpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lfpd_req_if.sink              req_chan,
   lfpd_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   csr_regs_type              csr_ff, csr_in;
   ctrl_word_type             ctrl;
   logic                      busy, start, restart_flag;
   logic                      out_free, out_load;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] left_ff, right_ff;
   logic signed [SPEED_W-1:0] left_calc, right_calc;

   // Register writes, masked to each register's width
   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_P:          csr_in.gain_p          = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_I:          csr_in.gain_i          = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_D:          csr_in.gain_d          = csr_wr_data[GAIN_W-1:0];
            CSR_SUM_LIMIT:       csr_in.sum_limit       = csr_wr_data[LIMIT_W-1:0];
            CSR_SPEED_STRAIGHT:  csr_in.speed_straight  = csr_wr_data[SPD_W-1:0];
            CSR_SPEED_LOW:       csr_in.speed_low       = csr_wr_data[SPD_W-1:0];
            CSR_POST_TURN_LIMIT: csr_in.post_turn_limit = csr_wr_data[PTL_W-1:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.gain_p          <= GAIN_P_RST;
         csr_ff.gain_i          <= GAIN_I_RST;
         csr_ff.gain_d          <= GAIN_D_RST;
         csr_ff.sum_limit       <= SUM_LIM_RST;
         csr_ff.speed_straight  <= STRAIGHT_RST;
         csr_ff.speed_low       <= LOW_RST;
         csr_ff.post_turn_limit <= PTL_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Take a sample whenever the sequencer is idle
   assign req_chan.ready = !busy;
   assign start          = req_chan.valid && !busy;

   lfpd_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .restart_flag (restart_flag),
      .emit_wait    (!out_free),
      .ctrl         (ctrl),
      .busy         (busy)
   );

   lfpd_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .position     (req_chan.position),
      .turn_ahead   (req_chan.turn_ahead),
      .after_turn   (req_chan.after_turn),
      .restart      (req_chan.restart),
      .ctrl         (ctrl),
      .csr          (csr_ff),
      .restart_flag (restart_flag),
      .left_speed   (left_calc),
      .right_speed  (right_calc)
   );

   // Result register: load on the final step once the previous transfer drains
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign out_load     = (ctrl.st_op == ST_EMIT) && out_free;
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff  <= left_calc;
         right_ff <= right_calc;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_speed  = left_ff;
   assign rsp_chan.right_speed = right_ff;

endmodule

/* verif/tb_line_follow_pid_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_follow_pid_drive: self-checking bench for the line follower drive
// Feeds position samples with turn flags through the request channel, keeps
// a cycle-free model of the PID loop and the speed slew, and compares every
// wheel speed pair that leaves the response channel with its prediction.
// Runs a directed set at reset defaults, then random track-like sequences
// under a series of register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_line_follow_pid_drive;
   import lfpd_pkg::*;

   localparam int          PHASES          = 10;
   localparam int          ITEMS_PER_PHASE = 160;
   localparam int          HOLD_PHASE      = 4;
   localparam int          PAUSE_PHASE     = 6;
   localparam int          LONG_HOLD       = 300;
   localparam int          TAIL_CYCLES     = 40;
   localparam longint      TIMEOUT_NS      = 64'd20_000_000;
   localparam int          SCALE_DIV       = 1500;
   localparam int          SPAN_DIV        = 2000;
   localparam int          LEAK_DIV        = 32;
   localparam int          RISE_STEP       = 4;
   localparam int          FALL_STEP       = 12;
   // index past the end of the register map, must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef enum logic [1:0] {
      TRACK_CRUISE   = 2'd0,
      TRACK_APPROACH = 2'd1,
      TRACK_RESTART  = 2'd2,
      TRACK_AFTER    = 2'd3
   } track_phase_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts wheel speeds per sample and checks them in order
   // -------------------------------------------------------------------------
   class drive_scoreboard;
      typedef struct {
         logic signed [SPEED_W-1:0] left;
         logic signed [SPEED_W-1:0] right;
      } wheel_pair_type;

      csr_regs_type   regs;
      int             prev_err;
      int             slope_avg;
      int             err_sum;
      int             cruise_speed;
      wheel_pair_type expected_wheels[$];
      int             failures;
      int             samples;
      int             results;
      int             restarts;
      int             near_turn;

      function new();
         regs.gain_p          = GAIN_P_RST;
         regs.gain_i          = GAIN_I_RST;
         regs.gain_d          = GAIN_D_RST;
         regs.sum_limit       = SUM_LIM_RST;
         regs.speed_straight  = STRAIGHT_RST;
         regs.speed_low       = LOW_RST;
         regs.post_turn_limit = PTL_RST;
         prev_err     = 0;
         slope_avg    = 0;
         err_sum      = 0;
         cruise_speed = int'(LOW_RST);
         failures     = 0;
         samples      = 0;
         results      = 0;
         restarts     = 0;
         near_turn    = 0;
      endfunction

      function longint bound(input longint v, input longint lim);
         if (v < -lim)
            return -lim;
         if (v > lim)
            return lim;
         return v;
      endfunction

      // Mirror a register write, masked to the register's width
      function void write_reg(input logic [CSR_IDX_W-1:0] index,
                              input logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_GAIN_P:          regs.gain_p          = data[GAIN_W-1:0];
            CSR_GAIN_I:          regs.gain_i          = data[GAIN_W-1:0];
            CSR_GAIN_D:          regs.gain_d          = data[GAIN_W-1:0];
            CSR_SUM_LIMIT:       regs.sum_limit       = data[LIMIT_W-1:0];
            CSR_SPEED_STRAIGHT:  regs.speed_straight  = data[SPD_W-1:0];
            CSR_SPEED_LOW:       regs.speed_low       = data[SPD_W-1:0];
            CSR_POST_TURN_LIMIT: regs.post_turn_limit = data[PTL_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the loop by one sample and queue the wheel speeds it gives
      function void note_sample(input logic [POS_W-1:0] position,
                                input logic turn_ahead,
                                input logic after_turn,
                                input logic restart);
         int             pos;
         int             err;
         int             mag;
         int             target;
         longint         corr;
         longint         left;
         longint         right;
         wheel_pair_type wheels;

         pos = int'(position);
         if (pos > int'(POS_MAX))
            pos = int'(POS_MAX);
         err = pos - int'(POS_CENTRE);
         mag = (err < 0) ? -err : err;

         // reload the loop as at the end of a turn
         if (restart) begin
            prev_err     = err;
            slope_avg    = 0;
            err_sum      = 0;
            cruise_speed = int'(regs.speed_low);
         end

         slope_avg = (slope_avg + (err - prev_err)) / 2;

         // leaky integral, then clamp
         err_sum = err_sum + err;
         err_sum = err_sum - err_sum / LEAK_DIV;
         err_sum = int'(bound(longint'(err_sum), longint'(regs.sum_limit)));

         corr = longint'(regs.gain_p) * err + longint'(regs.gain_i) * err_sum
              + longint'(regs.gain_d) * slope_avg;
         corr = (corr * (SCALE_DIV + mag)) / SCALE_DIV;
         if (after_turn)
            corr = bound(corr, longint'(regs.post_turn_limit));

         // target speed, then slew the cruise speed toward it
         if (turn_ahead || after_turn) begin
            target = int'(regs.speed_low);
         end else begin
            target = int'(regs.speed_straight)
                   + (mag * (int'(regs.speed_low) - int'(regs.speed_straight))) / SPAN_DIV;
         end
         if (target > cruise_speed)
            cruise_speed = (target < cruise_speed + RISE_STEP) ? target
                                                               : cruise_speed + RISE_STEP;
         else
            cruise_speed = (target > cruise_speed - FALL_STEP) ? target
                                                               : cruise_speed - FALL_STEP;

         left  = bound(longint'(cruise_speed) + corr, longint'(SAT_LIMIT));
         right = bound(longint'(cruise_speed) - corr, longint'(SAT_LIMIT));
         wheels.left  = SPEED_W'(left);
         wheels.right = SPEED_W'(right);
         expected_wheels.push_back(wheels);
         prev_err = err;

         samples++;
         if (restart)
            restarts++;
         if (turn_ahead || after_turn)
            near_turn++;
      endfunction

      // Compare one wheel speed pair with the oldest prediction
      function void check_wheels(input logic signed [SPEED_W-1:0] left,
                                 input logic signed [SPEED_W-1:0] right);
         wheel_pair_type want;

         if (expected_wheels.size() == 0) begin
            $error("wheel speeds with no sample waiting: left_speed %0d, right_speed %0d",
                   left, right);
            failures++;
            return;
         end
         want = expected_wheels.pop_front();
         results++;
         if (want.left !== left) begin
            $error("left_speed mismatch: expected %0d, got %0d", want.left, left);
            failures++;
         end
         if (want.right !== right) begin
            $error("right_speed mismatch: expected %0d, got %0d", want.right, right);
            failures++;
         end
      endfunction

      function int pending();
         return expected_wheels.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lfpd_req_if req_chan ();
   lfpd_rsp_if rsp_chan ();

   drive_scoreboard sb = new();

   logic            send_gaps_on   = 1'b0;
   logic            recv_stalls_on = 1'b0;
   int              hold_off_cycles = 0;
   track_phase_type track_state = TRACK_CRUISE;
   int              track_pos   = 2000;
   int              track_left  = 0;

   always #5 clock = ~clock;

   line_follow_pid_drive dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Watch both channels; note samples and check results on each transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_wheels(rsp_chan.left_speed, rsp_chan.right_speed);
         if (req_chan.valid && req_chan.ready)
            sb.note_sample(req_chan.position, req_chan.turn_ahead,
                           req_chan.after_turn, req_chan.restart);
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Response side: random stalls, plus a long hold-off on request
   initial begin : drain
      int stall_left;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_chan.ready = 1'b0;
            hold_off_cycles--;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else if (recv_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            rsp_chan.ready = (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // Give up after a generous fixed time
   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAIL line_follow_pid_drive");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Driving tasks
   // -------------------------------------------------------------------------

   // Offer one sample and hold it until the transfer; returns at a falling edge
   task automatic send_sample(input logic [POS_W-1:0] position, input logic turn_ahead,
                              input logic after_turn, input logic restart);
      int gap;
      gap = send_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.position   = position;
      req_chan.turn_ahead = turn_ahead;
      req_chan.after_turn = after_turn;
      req_chan.restart    = restart;
      req_chan.valid      = 1'b1;
      do
         @(posedge clock);
      while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Drop the request and wait until every predicted result has arrived
   task automatic wait_drained();
      req_chan.valid = 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] index,
                          input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   = 1'b1;
      csr_index   = index;
      csr_wr_data = data;
      sb.write_reg(index, data);
      @(negedge clock);
   endtask

   // Write the whole register map, plus a stray write past its end
   task automatic apply_settings(input logic [CSR_DATA_W-1:0] gain_p,
                                 input logic [CSR_DATA_W-1:0] gain_i,
                                 input logic [CSR_DATA_W-1:0] gain_d,
                                 input logic [CSR_DATA_W-1:0] sum_limit,
                                 input logic [CSR_DATA_W-1:0] straight,
                                 input logic [CSR_DATA_W-1:0] low,
                                 input logic [CSR_DATA_W-1:0] turn_limit);
      csr_put(CSR_GAIN_P, gain_p);
      csr_put(CSR_GAIN_I, gain_i);
      csr_put(CSR_GAIN_D, gain_d);
      csr_put(CSR_SUM_LIMIT, sum_limit);
      csr_put(CSR_SPEED_STRAIGHT, straight);
      csr_put(CSR_SPEED_LOW, low);
      csr_put(CSR_POST_TURN_LIMIT, turn_limit);
      csr_put(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_wr_en = 1'b0;
   endtask

   // One sample of a wandering track with turn episodes, or plain noise
   task automatic send_track_sample();
      logic [POS_W-1:0] position;
      logic             turn_ahead;
      logic             after_turn;
      logic             restart;

      turn_ahead = 1'b0;
      after_turn = 1'b0;
      restart    = 1'b0;
      if ($urandom_range(0, 5) == 0) begin
         // noise: any position, any flag combination
         position = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(4001, 4095))
                                                : POS_W'($urandom_range(0, 4095));
         {turn_ahead, after_turn, restart} = 3'($urandom_range(0, 7));
      end else begin
         case (track_state)
            TRACK_CRUISE: begin
               if ($urandom_range(0, 24) == 0) begin
                  track_state = TRACK_APPROACH;
                  track_left  = $urandom_range(2, 6);
               end
            end
            TRACK_APPROACH: begin
               turn_ahead = 1'b1;
               track_left--;
               if (track_left == 0)
                  track_state = TRACK_RESTART;
            end
            TRACK_RESTART: begin
               // new line picked up after the turn
               restart     = 1'b1;
               after_turn  = 1'($urandom_range(0, 1));
               track_pos   = $urandom_range(1500, 2500);
               track_state = TRACK_AFTER;
               track_left  = $urandom_range(2, 8);
            end
            TRACK_AFTER: begin
               after_turn = 1'b1;
               track_left--;
               if (track_left == 0)
                  track_state = TRACK_CRUISE;
            end
         endcase
         // wander, and now and then lose the line to one side
         if (!restart) begin
            track_pos = track_pos + int'($urandom_range(0, 300)) - 150;
            if ($urandom_range(0, 19) == 0)
               track_pos = $urandom_range(0, 1) ? int'(POS_MAX) : 0;
         end
         if (track_pos < 0)
            track_pos = 0;
         if (track_pos > int'(POS_MAX))
            track_pos = int'(POS_MAX);
         position = POS_W'(track_pos);
      end
      send_sample(position, turn_ahead, after_turn, restart);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                    phase;
      int                    k;
      logic [CSR_DATA_W-1:0] gp;
      logic [CSR_DATA_W-1:0] lim;

      req_chan.valid      = 1'b0;
      req_chan.position   = '0;
      req_chan.turn_ahead = 1'b0;
      req_chan.after_turn = 1'b0;
      req_chan.restart    = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = '0;
      csr_wr_data         = '0;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed samples at reset defaults
      send_sample(12'd2000, 1'b0, 1'b0, 1'b0);
      send_sample(12'd0,    1'b0, 1'b0, 1'b0);
      send_sample(12'd4000, 1'b0, 1'b0, 1'b0);
      send_sample(12'd4095, 1'b0, 1'b0, 1'b0);
      send_sample(12'd4001, 1'b0, 1'b0, 1'b0);
      send_sample(12'd1999, 1'b0, 1'b0, 1'b0);
      send_sample(12'd2001, 1'b0, 1'b0, 1'b0);
      send_sample(12'hAAA,  1'b0, 1'b0, 1'b0);
      send_sample(12'h555,  1'b0, 1'b0, 1'b0);
      send_sample(12'd3000, 1'b1, 1'b0, 1'b0);
      send_sample(12'd0,    1'b0, 1'b1, 1'b0);
      send_sample(12'd4000, 1'b0, 1'b1, 1'b0);
      send_sample(12'd1000, 1'b0, 1'b0, 1'b1);
      send_sample(12'd3500, 1'b1, 1'b1, 1'b1);
      send_sample(12'd2000, 1'b0, 1'b0, 1'b1);
      send_sample(12'd500,  1'b0, 1'b0, 1'b0);
      send_sample(12'd4000, 1'b1, 1'b1, 1'b0);
      send_sample(12'd0,    1'b0, 1'b0, 1'b1);
      send_sample(12'd2048, 1'b0, 1'b0, 1'b0);
      send_sample(12'd2047, 1'b0, 1'b0, 1'b0);

      for (phase = 1; phase <= PHASES; phase++) begin
         wait_drained();
         case (phase)
            // junk in the upper bits, masked values are ordinary
            1: apply_settings(16'hA302, 16'h0101, 16'hFF08, 16'd3000,
                              16'hFF2C, 16'hFE96, 16'hFCC8);
            2: apply_settings(16'd255, 16'd255, 16'd255, 16'hFFFF,
                              16'd400, 16'd0, 16'd800);
            3: apply_settings(16'd0, 16'd0, 16'd0, 16'd0,
                              16'd0, 16'd0, 16'd0);
            // target rises with the error
            4: apply_settings(16'd1, 16'd2, 16'd6, 16'd8000,
                              16'd0, 16'd400, 16'd100);
            default: begin
               gp  = ($urandom_range(0, 7) == 0) ? 16'd255 : 16'($urandom_range(0, 4));
               lim = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, 6000));
               apply_settings(gp, 16'($urandom_range(0, 3)), 16'($urandom_range(0, 20)),
                              lim, 16'($urandom_range(0, 400)),
                              16'($urandom_range(0, 400)), 16'($urandom_range(0, 800)));
            end
         endcase
         send_gaps_on   = (phase % 4 == 1) || (phase % 4 == 3);
         recv_stalls_on = (phase % 4 >= 2);

         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            // hold the response side off while samples keep coming
            if (phase == HOLD_PHASE && k == ITEMS_PER_PHASE / 4)
               hold_off_cycles = LONG_HOLD;
            // stop offering until the block has emptied
            if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
               wait_drained();
            send_track_sample();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d samples (%0d with restart, %0d near a turn) under %0d settings,",
               sb.samples, sb.restarts, sb.near_turn, PHASES + 1);
      $display("checked %0d wheel speed pairs with idling and stalls on both channels.",
               sb.results);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASS line_follow_pid_drive");
      end else begin
         $display("FAIL line_follow_pid_drive");
      end
      $finish;
   end

endmodule
